// ===== hw/rtl/ieu_pkg.sv =====
// ----------------------------------------------------------------------------
// Instruction execute unit package
// Shared opcodes, result codes, SPR numbers, masks and the payload types.
// ----------------------------------------------------------------------------
package ieu_pkg;

  typedef enum logic [5:0] {
    OP_ADD = 6'd0, OP_ADD_IMM = 6'd1, OP_AND_IMM = 6'd2, OP_ANDC = 6'd3,
    OP_BDNZ = 6'd4, OP_BEQ = 6'd5, OP_BLR = 6'd6, OP_BNE = 6'd7,
    OP_BRANCH = 6'd8, OP_BRANCH_LINK = 6'd9, OP_CMPLW_IMM = 6'd10,
    OP_EIEIO = 6'd11, OP_ISYNC = 6'd12, OP_LOAD_IMM = 6'd13, OP_LWAR = 6'd14,
    OP_LWARX = 6'd15, OP_MFMSR = 6'd16, OP_MFSPR = 6'd17, OP_MTSPR = 6'd18,
    OP_MTCTR = 6'd19, OP_OR = 6'd20, OP_OR_IMM = 6'd21, OP_RFID = 6'd22,
    OP_SLBIA = 6'd23, OP_SLBMTE = 6'd24, OP_SLD_IMM = 6'd25, OP_SLW = 6'd26,
    OP_SLW_IMM = 6'd27, OP_STD = 6'd28, OP_STD_OFF = 6'd29, OP_STWC = 6'd30,
    OP_STWCX = 6'd31, OP_SUBF = 6'd32, OP_SYNC = 6'd33, OP_TLBIEL = 6'd34,
    OP_ISI = 6'd35
  } opcode_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0, ERR_SPR = 2'd1, ERR_OPCODE = 2'd2
  } err_e;

  localparam logic [63:0] SprSrr0  = 64'd26;
  localparam logic [63:0] SprSrr1  = 64'd27;
  localparam logic [63:0] SprSprg0 = 64'd272;
  localparam logic [63:0] SprSprg1 = 64'd273;
  localparam logic [63:0] SprHrmor = 64'd313;
  localparam logic [63:0] SprLpcr  = 64'd318;
  localparam logic [63:0] SprLpidr = 64'd319;
  localparam logic [63:0] SprHid6  = 64'd1017;
  localparam logic [63:0] SprPir   = 64'd1023;

  localparam logic [63:0] MsrSf       = 64'h8000000000000000;
  localparam logic [63:0] MsrMask     = 64'h900000000200FF37;
  localparam logic [63:0] MsrRelocOff = 64'hFFFFFFFFFFFFFFCF;
  localparam logic [63:0] Low32       = 64'h00000000FFFFFFFF;
  localparam logic [63:0] IsiVector   = 64'h400;

  typedef struct packed {
    logic [5:0]  opcode;
    logic [63:0] arg_first;
    logic [63:0] arg_second;
    logic [63:0] arg_third;
    logic [63:0] instr_address;
  } instr_t;

  typedef struct packed {
    logic        redirect;
    logic [63:0] next_pc;
    logic [1:0]  error_code;
    logic        hrmor_write;
    logic [63:0] hrmor_value;
    logic [63:0] msr_value;
  } result_t;

endpackage

// ===== hw/rtl/ieu_instr_if.sv =====
// ----------------------------------------------------------------------------
// Instruction channel
// Valid/ready channel that carries one decoded instruction per request.
// ----------------------------------------------------------------------------
interface ieu_instr_if;
  logic             valid;
  logic             ready;
  ieu_pkg::instr_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/ieu_result_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one execution result per request.
// ----------------------------------------------------------------------------
interface ieu_result_if;
  logic             valid;
  logic             ready;
  ieu_pkg::result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/ieu_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel for the thread number register.
// ----------------------------------------------------------------------------
interface ieu_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ieu_out_buf.sv =====
// ----------------------------------------------------------------------------
// Result skid buffer
// Two-entry output stage so the core keeps accepting while results wait.
// ----------------------------------------------------------------------------
module ieu_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ieu_pkg::result_t data_i,
  output logic             space_o,
  ieu_result_if.source     res
);
  import ieu_pkg::*;

  result_t main_q, skid_q;
  logic    main_vld_q, skid_vld_q;
  logic    pop;

  assign pop         = main_vld_q && res.ready;
  assign space_o     = !skid_vld_q;
  assign res.valid   = main_vld_q;
  assign res.payload = main_q;

  // Valid bits: a push lands in skid when main is held or skid moves to main.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (!main_vld_q || pop) begin
        main_vld_q <= skid_vld_q || push_i;
        skid_vld_q <= skid_vld_q && push_i;
      end else if (push_i) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  // Payload moves from skid to main in order.
  always_ff @(posedge clk_i) begin
    if (!main_vld_q || pop) begin
      if (skid_vld_q) begin
        main_q <= skid_q;
        if (push_i) begin
          skid_q <= data_i;
        end
      end else if (push_i) begin
        main_q <= data_i;
      end
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

endmodule

// ===== hw/rtl/ir_instruction_execute_unit.sv =====
// ----------------------------------------------------------------------------
// IR instruction execute unit
// Executes one decoded instruction per cycle unless stalled, on architected state.
// ----------------------------------------------------------------------------
// Usage: instructions enter on instr_i, one request per cycle when ready is
// high. Each instruction is registered at the input, executed against the
// GPRs, SPRs and the data store, and its result is placed in a two-entry
// output buffer, from which results leave on result_o in order. Throughput
// is one instruction per cycle while the buffer has room; the rate is set
// by the single execute stage, whose register and store updates complete
// in the cycle the instruction executes, so the next
// instruction sees them. The data store is a one-write memory read into a
// data register when the instruction is accepted; the GPR result and any
// store of the instruction executing in that cycle are forwarded to it.
// A reset clears all architected registers, the reservation and the output
// buffer. The data store is cleared by a sweep over DATA_WORDS words after
// reset, during which no instruction is accepted; configuration writes are
// taken at any time. When the receiver stalls, the buffer fills and ready
// drops, holding the instruction in the input register.
// cfg_i writes the 6-bit thread number read back through SPR 1023.
// ----------------------------------------------------------------------------
module ir_instruction_execute_unit #(
  parameter int DATA_WORDS = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ieu_cfg_if.sink      cfg_i,
  ieu_instr_if.sink    instr_i,
  ieu_result_if.source result_o
);
  import ieu_pkg::*;

  localparam int AW = $clog2(DATA_WORDS);

  // Input register.
  instr_t  in_q;
  logic    in_vld_q;
  logic    space, exec, clr_busy;

  assign exec = in_vld_q && space;
  assign instr_i.ready = !clr_busy && (!in_vld_q || space);
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (instr_i.ready) begin
      in_vld_q <= instr_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (instr_i.ready && instr_i.valid) begin
      in_q <= instr_i.payload;
    end
  end

  // Thread number register.
  logic [5:0] tid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tid_q <= '0;
    end else if (cfg_i.valid) begin
      tid_q <= cfg_i.data;
    end
  end

  // Architected state.
  logic [31:0][63:0] gpr_q;
  logic [3:0]  cr_q;
  logic [63:0] ctr_q, lr_q, msr_q, srr0_q, srr1_q, sprg0_q, sprg1_q;
  logic [63:0] lpcr_q, lpidr_q, hid6_q, resv_addr_q;
  logic        resv_vld_q;
  logic [63:0] mem_q [DATA_WORDS];
  logic [AW:0] clr_cnt_q;

  assign clr_busy = !clr_cnt_q[AW];

  // Execute logic.
  logic [4:0]  ia, ib, ic;
  logic [63:0] ra, rb, rc, word32, ctr_dec;
  logic [63:0] addr_q, mem_rd_q;
  logic [AW-1:0] widx;
  logic        gpr_we, ctr_we, lr_we, cr_we, mem_we, resv_set, resv_clr;
  logic        msr_we, srr_we, spr_we;
  logic [63:0] gpr_wd, mem_wd, rb_slw;
  logic [3:0]  cr_wd;
  logic [5:0]  sh6;
  result_t     res;

  // Acceptance-side address path.
  logic [4:0]    nb, nc;
  logic [63:0]   nrb, nrc, naddr;
  logic [AW-1:0] nidx;

  assign ia = in_q.arg_first[4:0];
  assign ib = in_q.arg_second[4:0];
  assign ic = in_q.arg_third[4:0];
  assign ra = gpr_q[ia];
  assign rb = gpr_q[ib];
  assign rc = gpr_q[ic];
  assign ctr_dec = ctr_q - 64'd1;

  assign widx = addr_q[AW+2:3];
  assign word32 = addr_q[2] ? {32'd0, mem_rd_q[31:0]} : {32'd0, mem_rd_q[63:32]};
  assign rb_slw = (in_q.opcode == OP_SLW) ? rc : in_q.arg_third;
  assign sh6 = rb_slw[5:0];

  always_comb begin
    res = '0;
    res.error_code = ERR_NONE;
    gpr_we = 1'b0; gpr_wd = '0;
    ctr_we = 1'b0; lr_we = 1'b0; cr_we = 1'b0; cr_wd = '0;
    mem_we = 1'b0; mem_wd = ra;
    resv_set = 1'b0; resv_clr = 1'b0;
    msr_we = 1'b0; srr_we = 1'b0; spr_we = 1'b0;
    case (in_q.opcode)
      OP_ADD:     begin gpr_we = 1'b1; gpr_wd = rb + rc; end
      OP_ADD_IMM: begin gpr_we = 1'b1; gpr_wd = rb + in_q.arg_third; end
      OP_AND_IMM: begin gpr_we = 1'b1; gpr_wd = rb & in_q.arg_third; end
      OP_ANDC:    begin gpr_we = 1'b1; gpr_wd = rb & ~rc; end
      OP_OR:      begin gpr_we = 1'b1; gpr_wd = rb | rc; end
      OP_OR_IMM:  begin gpr_we = 1'b1; gpr_wd = rb | in_q.arg_third; end
      OP_SUBF:    begin gpr_we = 1'b1; gpr_wd = rc - rb; end
      OP_LOAD_IMM: begin gpr_we = 1'b1; gpr_wd = in_q.arg_second; end
      OP_MFMSR:   begin gpr_we = 1'b1; gpr_wd = msr_q; end
      OP_SLD_IMM: begin
        gpr_we = 1'b1;
        gpr_wd = in_q.arg_third[6] ? 64'd0 : (rb << in_q.arg_third[5:0]);
      end
      OP_SLW, OP_SLW_IMM: begin
        gpr_we = 1'b1;
        gpr_wd = sh6[5] ? 64'd0 : {32'd0, rb[31:0] << sh6[4:0]};
      end
      OP_BDNZ: begin
        ctr_we = 1'b1;
        res.redirect = (ctr_dec != 64'd0);
        res.next_pc = res.redirect ? in_q.arg_first : 64'd0;
      end
      OP_BEQ: begin
        res.redirect = cr_q[1];
        res.next_pc = cr_q[1] ? in_q.arg_first : 64'd0;
      end
      OP_BNE: begin
        res.redirect = !cr_q[1];
        res.next_pc = !cr_q[1] ? in_q.arg_first : 64'd0;
      end
      OP_BLR: begin
        res.redirect = 1'b1;
        res.next_pc = ((msr_q & MsrSf) != 64'd0) ? lr_q : (lr_q & Low32);
      end
      OP_BRANCH: begin res.redirect = 1'b1; res.next_pc = in_q.arg_first; end
      OP_BRANCH_LINK: begin
        res.redirect = 1'b1; res.next_pc = in_q.arg_first; lr_we = 1'b1;
      end
      OP_CMPLW_IMM: begin
        cr_we = 1'b1;
        if (ra[31:0] < in_q.arg_second[31:0]) cr_wd = 4'd8;
        else if (ra[31:0] > in_q.arg_second[31:0]) cr_wd = 4'd4;
        else cr_wd = 4'd2;
      end
      OP_LWAR: begin gpr_we = 1'b1; gpr_wd = word32; resv_set = 1'b1; end
      OP_MFSPR: begin
        gpr_we = 1'b1;
        if (in_q.arg_second == SprSprg0) gpr_wd = sprg0_q;
        else if (in_q.arg_second == SprSprg1) gpr_wd = sprg1_q;
        else if (in_q.arg_second == SprLpcr) gpr_wd = lpcr_q;
        else if (in_q.arg_second == SprHid6) gpr_wd = hid6_q;
        else if (in_q.arg_second == SprPir) gpr_wd = {58'd0, tid_q};
        else begin gpr_we = 1'b0; res.error_code = ERR_SPR; end
      end
      OP_MTSPR: begin
        spr_we = 1'b1;
        if (in_q.arg_second == SprHrmor) begin
          res.hrmor_write = 1'b1; res.hrmor_value = ra;
        end else if (!(in_q.arg_second == SprSrr0 || in_q.arg_second == SprSrr1 ||
                       in_q.arg_second == SprSprg0 || in_q.arg_second == SprSprg1 ||
                       in_q.arg_second == SprLpcr || in_q.arg_second == SprLpidr ||
                       in_q.arg_second == SprHid6)) begin
          res.error_code = ERR_SPR;
        end
      end
      OP_MTCTR: ctr_we = 1'b1;
      OP_RFID: begin
        msr_we = 1'b1; res.redirect = 1'b1; res.next_pc = srr0_q;
      end
      OP_STD, OP_STD_OFF: mem_we = 1'b1;
      OP_STWC: begin
        cr_we = 1'b1; resv_clr = 1'b1;
        if (resv_vld_q && resv_addr_q == addr_q) begin
          cr_wd = 4'd2; mem_we = 1'b1;
          mem_wd = addr_q[2] ? {mem_rd_q[63:32], ra[31:0]}
                             : {ra[31:0], mem_rd_q[31:0]};
        end
      end
      OP_EIEIO, OP_ISYNC, OP_SLBIA, OP_SLBMTE, OP_SYNC, OP_TLBIEL: ;
      OP_ISI: begin
        srr_we = 1'b1; msr_we = 1'b1;
        res.redirect = 1'b1; res.next_pc = IsiVector;
      end
      default: res.error_code = ERR_OPCODE;
    endcase
    // MSR after this instruction.
    if (msr_we) begin
      res.msr_value = (in_q.opcode == OP_RFID) ? (srr1_q & MsrMask)
                                               : (msr_q & MsrRelocOff & MsrMask);
    end else begin
      res.msr_value = msr_q;
    end
  end

  // Address of the incoming instruction, with the executing GPR write forwarded.
  assign nb = instr_i.payload.arg_second[4:0];
  assign nc = instr_i.payload.arg_third[4:0];
  assign nrb = (exec && gpr_we && ia == nb) ? gpr_wd : gpr_q[nb];
  assign nrc = (exec && gpr_we && ia == nc) ? gpr_wd : gpr_q[nc];
  assign naddr = (instr_i.payload.opcode == OP_STD_OFF) ?
                 nrc + instr_i.payload.arg_second : nrb;
  assign nidx = naddr[AW+2:3];

  always_ff @(posedge clk_i) begin
    if (instr_i.ready && instr_i.valid) begin
      addr_q <= naddr;
    end
  end

  // State update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gpr_q <= '0; cr_q <= '0; ctr_q <= '0; lr_q <= '0; msr_q <= '0;
      srr0_q <= '0; srr1_q <= '0; sprg0_q <= '0; sprg1_q <= '0;
      lpcr_q <= '0; lpidr_q <= '0; hid6_q <= '0;
      resv_vld_q <= 1'b0; resv_addr_q <= '0;
    end else if (exec) begin
      if (gpr_we) gpr_q[ia] <= gpr_wd;
      if (cr_we) cr_q <= cr_wd;
      if (ctr_we) ctr_q <= (in_q.opcode == OP_MTCTR) ? ra : ctr_dec;
      if (lr_we) lr_q <= in_q.instr_address + 64'd4;
      if (msr_we) msr_q <= res.msr_value;
      if (srr_we) begin
        srr0_q <= in_q.instr_address; srr1_q <= msr_q;
      end
      if (spr_we && res.error_code == ERR_NONE) begin
        if (in_q.arg_second == SprSrr0) srr0_q <= ra;
        if (in_q.arg_second == SprSrr1) srr1_q <= ra;
        if (in_q.arg_second == SprSprg0) sprg0_q <= ra;
        if (in_q.arg_second == SprSprg1) sprg1_q <= ra;
        if (in_q.arg_second == SprLpcr) lpcr_q <= ra;
        if (in_q.arg_second == SprLpidr) lpidr_q <= ra;
        if (in_q.arg_second == SprHid6) hid6_q <= ra;
      end
      if (resv_set) begin resv_vld_q <= 1'b1; resv_addr_q <= addr_q; end
      if (resv_clr) resv_vld_q <= 1'b0;
    end
  end

  // Clearing sweep counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (clr_busy) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // Data store write port and registered read at acceptance.
  always_ff @(posedge clk_i) begin
    if (clr_busy) begin
      mem_q[clr_cnt_q[AW-1:0]] <= '0;
    end else if (exec && mem_we) begin
      mem_q[widx] <= mem_wd;
    end
    if (instr_i.ready && instr_i.valid) begin
      mem_rd_q <= (exec && mem_we && widx == nidx) ? mem_wd : mem_q[nidx];
    end
  end

  ieu_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (exec),
    .data_i  (res),
    .space_o (space),
    .res     (result_o)
  );

endmodule

// ===== hw/rtl/ieu_checker.sv =====
// ----------------------------------------------------------------------------
// Execute unit checker
// Port-level properties of the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
module ieu_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input ieu_pkg::result_t out_data_i
);
  import ieu_pkg::*;

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // The error code never takes its unused value.
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.error_code != 2'd3)
    else $error("bad error code");

  // Without a redirect the next pc reads zero.
  a_npc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.redirect |-> out_data_i.next_pc == 64'd0)
    else $error("next pc without redirect");

  // The MSR only shows implemented bits.
  a_msr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.msr_value & ~MsrMask) == 64'd0)
    else $error("unimplemented MSR bit set");

  // No HRMOR value without a write.
  a_hrmor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.hrmor_write |-> out_data_i.hrmor_value == 64'd0)
    else $error("HRMOR value without write");

endmodule

bind ir_instruction_execute_unit ieu_checker u_ieu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_data_i  (result_o.payload)
);

// ===== test/tb_ir_instruction_execute_unit_ifs.sv =====
// ----------------------------------------------------------------------------
// Testbench interface notes
// The channel interfaces come from the RTL tree; this file fixes the time
// unit and the clock period for the testbench side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Small holder for the testbench clock period.
package tb_ieu_pkg;
  localparam int ClkPeriod = 10;
endpackage

// ===== test/tb_ir_instruction_execute_unit.sv =====
// ----------------------------------------------------------------------------
// Execute unit testbench
// Sends decoded instructions with random idling on both channels, predicts
// each result with a private copy of the architected state and compares
// every result field in order. The thread number is set between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ir_instruction_execute_unit;
  import ieu_pkg::*;

  localparam int DataWords = 1024;
  localparam int CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ieu_cfg_if    cfg_ch();
  ieu_instr_if  instr_ch();
  ieu_result_if result_ch();

  ir_instruction_execute_unit #(.DATA_WORDS(DataWords)) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_ch.sink),
    .instr_i (instr_ch.sink),
    .result_o(result_ch.source)
  );

  always #(tb_ieu_pkg::ClkPeriod / 2) clk_i = ~clk_i;

  // Predicted architected state.
  logic [63:0] gpr_q [32];
  logic [3:0]  cr0_q;
  logic [63:0] ctr_q, lr_q, msr_q, srr0_q, srr1_q, sprg0_q, sprg1_q;
  logic [63:0] lpcr_q, lpidr_q, hid6_q, resv_addr_q;
  logic        resv_valid_q;
  logic [63:0] mem_q [DataWords];
  logic [5:0]  thread_q;

  result_t     pending_results[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  bit          idle_enable = 1'b1;
  int          hold_cycles = 0;

  function automatic int word_of(logic [63:0] addr);
    return int'((addr >> 3) % DataWords);
  endfunction

  function automatic logic [63:0] shift_word(logic [63:0] v, logic [63:0] amt);
    logic [31:0] lo;
    lo = v[31:0];
    if (amt[5:0] >= 32) return 64'd0;
    return {32'd0, lo << amt[5:0]};
  endfunction

  // Apply one instruction to the predicted state and return its result.
  function automatic result_t execute_instr(instr_t ins);
    result_t r;
    logic [63:0] a0, a1, a2, v, addr;
    logic [4:0] d, s1, s2;
    int w;
    r = '0;
    a0 = ins.arg_first; a1 = ins.arg_second; a2 = ins.arg_third;
    d = a0[4:0]; s1 = a1[4:0]; s2 = a2[4:0];
    case (ins.opcode)
      OP_ADD:     gpr_q[d] = gpr_q[s1] + gpr_q[s2];
      OP_ADD_IMM: gpr_q[d] = gpr_q[s1] + a2;
      OP_AND_IMM: gpr_q[d] = gpr_q[s1] & a2;
      OP_ANDC:    gpr_q[d] = gpr_q[s1] & ~gpr_q[s2];
      OP_BDNZ: begin
        ctr_q = ctr_q - 64'd1;
        if (ctr_q != 0) begin r.redirect = 1'b1; r.next_pc = a0; end
      end
      OP_BEQ: if (cr0_q[1]) begin r.redirect = 1'b1; r.next_pc = a0; end
      OP_BNE: if (!cr0_q[1]) begin r.redirect = 1'b1; r.next_pc = a0; end
      OP_BLR: begin
        r.redirect = 1'b1;
        r.next_pc = (msr_q & MsrSf) != 0 ? lr_q : (lr_q & Low32);
      end
      OP_BRANCH: begin r.redirect = 1'b1; r.next_pc = a0; end
      OP_BRANCH_LINK: begin
        r.redirect = 1'b1; r.next_pc = a0; lr_q = ins.instr_address + 64'd4;
      end
      OP_CMPLW_IMM: begin
        if (gpr_q[d][31:0] < a1[31:0]) cr0_q = 4'd8;
        else if (gpr_q[d][31:0] > a1[31:0]) cr0_q = 4'd4;
        else cr0_q = 4'd2;
      end
      OP_LOAD_IMM: gpr_q[d] = a1;
      OP_LWAR: begin
        addr = gpr_q[s1];
        resv_valid_q = 1'b1; resv_addr_q = addr;
        w = word_of(addr);
        gpr_q[d] = addr[2] ? {32'd0, mem_q[w][31:0]} : {32'd0, mem_q[w][63:32]};
      end
      OP_MFMSR: gpr_q[d] = msr_q;
      OP_MFSPR: begin
        if (a1 == SprSprg0) gpr_q[d] = sprg0_q;
        else if (a1 == SprSprg1) gpr_q[d] = sprg1_q;
        else if (a1 == SprLpcr) gpr_q[d] = lpcr_q;
        else if (a1 == SprHid6) gpr_q[d] = hid6_q;
        else if (a1 == SprPir) gpr_q[d] = {58'd0, thread_q};
        else r.error_code = ERR_SPR;
      end
      OP_MTSPR: begin
        v = gpr_q[d];
        if (a1 == SprSrr0) srr0_q = v;
        else if (a1 == SprSrr1) srr1_q = v;
        else if (a1 == SprSprg0) sprg0_q = v;
        else if (a1 == SprSprg1) sprg1_q = v;
        else if (a1 == SprHrmor) begin r.hrmor_write = 1'b1; r.hrmor_value = v; end
        else if (a1 == SprLpcr) lpcr_q = v;
        else if (a1 == SprLpidr) lpidr_q = v;
        else if (a1 == SprHid6) hid6_q = v;
        else r.error_code = ERR_SPR;
      end
      OP_MTCTR:  ctr_q = gpr_q[d];
      OP_OR:     gpr_q[d] = gpr_q[s1] | gpr_q[s2];
      OP_OR_IMM: gpr_q[d] = gpr_q[s1] | a2;
      OP_RFID: begin
        msr_q = srr1_q & MsrMask;
        r.redirect = 1'b1; r.next_pc = srr0_q;
      end
      OP_SLD_IMM: gpr_q[d] = (a2[6:0] >= 64) ? 64'd0 : (gpr_q[s1] << a2[6:0]);
      OP_SLW:     gpr_q[d] = shift_word(gpr_q[s1], gpr_q[s2]);
      OP_SLW_IMM: gpr_q[d] = shift_word(gpr_q[s1], a2);
      OP_STD:     mem_q[word_of(gpr_q[s1])] = gpr_q[d];
      OP_STD_OFF: mem_q[word_of(gpr_q[s2] + a1)] = gpr_q[d];
      OP_STWC: begin
        addr = gpr_q[s1];
        if (resv_valid_q && resv_addr_q == addr) begin
          w = word_of(addr);
          if (addr[2]) mem_q[w][31:0] = gpr_q[d][31:0];
          else mem_q[w][63:32] = gpr_q[d][31:0];
          cr0_q = 4'd2;
        end else begin
          cr0_q = 4'd0;
        end
        resv_valid_q = 1'b0;
      end
      OP_SUBF: gpr_q[d] = gpr_q[s2] - gpr_q[s1];
      OP_EIEIO, OP_ISYNC, OP_SLBIA, OP_SLBMTE, OP_SYNC, OP_TLBIEL: ;
      OP_ISI: begin
        srr0_q = ins.instr_address;
        srr1_q = msr_q;
        msr_q = msr_q & MsrRelocOff & MsrMask;
        r.redirect = 1'b1; r.next_pc = IsiVector;
      end
      default: r.error_code = ERR_OPCODE;
    endcase
    r.msr_value = msr_q;
    return r;
  endfunction

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= !(idle_enable && $urandom_range(99) < 7);
    end
  end

  // Compare each result against the oldest prediction.
  always @(posedge clk_i) begin
    result_t exp_r;
    result_t got_r;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      got_r = result_ch.payload;
      if (pending_results.size() == 0) begin
        $error("result with no prediction waiting");
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got_r.redirect !== exp_r.redirect) begin
          $error("redirect: expected %0h actual %0h", exp_r.redirect, got_r.redirect);
          fail_count++;
        end
        if (got_r.next_pc !== exp_r.next_pc) begin
          $error("next_pc: expected %0h actual %0h", exp_r.next_pc, got_r.next_pc);
          fail_count++;
        end
        if (got_r.error_code !== exp_r.error_code) begin
          $error("error_code: expected %0h actual %0h", exp_r.error_code,
                 got_r.error_code);
          fail_count++;
        end
        if (got_r.hrmor_write !== exp_r.hrmor_write) begin
          $error("hrmor_write: expected %0h actual %0h", exp_r.hrmor_write,
                 got_r.hrmor_write);
          fail_count++;
        end
        if (got_r.hrmor_value !== exp_r.hrmor_value) begin
          $error("hrmor_value: expected %0h actual %0h", exp_r.hrmor_value,
                 got_r.hrmor_value);
          fail_count++;
        end
        if (got_r.msr_value !== exp_r.msr_value) begin
          $error("msr_value: expected %0h actual %0h", exp_r.msr_value,
                 got_r.msr_value);
          fail_count++;
        end
      end
    end
  end

  // Send one instruction; the prediction is made at acceptance. Valid stays
  // high after acceptance until the next idle cycle or a drain.
  task automatic send_instr(instr_t ins);
    while (idle_enable && $urandom_range(99) < 7) begin
      instr_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    instr_ch.valid <= 1'b1;
    instr_ch.payload <= ins;
    do @(posedge clk_i); while (!instr_ch.ready);
    pending_results.push_back(execute_instr(ins));
  endtask

  task automatic drain_results();
    instr_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_thread(logic [5:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    thread_q = value;
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic instr_t make_instr(opcode_e op, logic [63:0] a0, logic [63:0] a1,
                                        logic [63:0] a2);
    instr_t ins;
    ins.opcode = op; ins.arg_first = a0; ins.arg_second = a1; ins.arg_third = a2;
    ins.instr_address = {$urandom, $urandom};
    return ins;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Pick a value biased toward the interesting corners.
  function automatic logic [63:0] rand_value();
    case ($urandom_range(5))
      0: return 64'd0;
      1: return '1;
      2: return 64'(32'hFFFF_FFFF);
      3: return 64'($urandom_range(70));
      default: return rand64();
    endcase
  endfunction

  function automatic logic [63:0] rand_spr();
    logic [63:0] sprs [10];
    sprs = '{SprSrr0, SprSrr1, SprSprg0, SprSprg1, SprHrmor, SprLpcr, SprLpidr,
             SprHid6, SprPir, 64'd5};
    return ($urandom_range(9) == 0) ? rand64() : sprs[$urandom_range(9)];
  endfunction

  // Build a random instruction; addresses are kept on a few words so
  // reservations and stores hit each other.
  function automatic instr_t rand_instr();
    instr_t ins;
    ins = make_instr(opcode_e'($urandom_range(35)), rand64(), rand64(), rand_value());
    if ($urandom_range(19) == 0) ins.opcode = 6'($urandom_range(63, 36));
    if ($urandom_range(1)) ins.arg_first = 64'($urandom_range(31));
    if ($urandom_range(1)) ins.arg_second = 64'($urandom_range(31));
    if ($urandom_range(1)) ins.arg_third = 64'($urandom_range(31));
    if (ins.opcode == OP_MFSPR || ins.opcode == OP_MTSPR) ins.arg_second = rand_spr();
    if (ins.opcode == OP_LOAD_IMM) ins.arg_second = rand_value();
    return ins;
  endfunction

  // Directed: corners of many opcodes and the special cases.
  task automatic test_directed();
    send_instr(make_instr(OP_LOAD_IMM, 64'd1, '1, 0));
    send_instr(make_instr(OP_LOAD_IMM, 64'd34, 64'h8000_0000_0000_0010, 0));
    send_instr(make_instr(OP_ADD, 64'd3, 64'd1, 64'd2));
    send_instr(make_instr(OP_ADD_IMM, 64'd4, 64'd1, 64'd1));
    send_instr(make_instr(OP_AND_IMM, 64'd5, 64'd1, 64'hF0F0));
    send_instr(make_instr(OP_ANDC, 64'd6, 64'd1, 64'd2));
    send_instr(make_instr(OP_SLD_IMM, 64'd7, 64'd1, 64'd64));
    send_instr(make_instr(OP_SLD_IMM, 64'd8, 64'd1, 64'd63));
    send_instr(make_instr(OP_SLW_IMM, 64'd9, 64'd1, 64'd31));
    send_instr(make_instr(OP_SLW_IMM, 64'd10, 64'd1, 64'd32));
    send_instr(make_instr(OP_SLW, 64'd11, 64'd1, 64'd4));
    send_instr(make_instr(OP_CMPLW_IMM, 64'd1, 64'hFFFF_FFFF, 0));
    send_instr(make_instr(OP_BEQ, 64'h1234, 0, 0));
    send_instr(make_instr(OP_BNE, 64'h5678, 0, 0));
    send_instr(make_instr(OP_LWAR, 64'd12, 64'd2, 0));
    send_instr(make_instr(OP_STWC, 64'd1, 64'd2, 0));
    send_instr(make_instr(OP_STWC, 64'd1, 64'd2, 0));
    send_instr(make_instr(OP_MTSPR, 64'd1, SprHrmor, 0));
    send_instr(make_instr(OP_MTSPR, 64'd2, SprSrr1, 0));
    send_instr(make_instr(OP_MFSPR, 64'd13, SprPir, 0));
    send_instr(make_instr(OP_MFSPR, 64'd13, 64'd5, 0));
    send_instr(make_instr(OP_RFID, 0, 0, 0));
    send_instr(make_instr(OP_BLR, 0, 0, 0));
    send_instr(make_instr(OP_ISI, 0, 0, 0));
    send_instr(make_instr(OP_LWARX, 0, 0, 0));
    send_instr(make_instr(opcode_e'(6'd63), 0, 0, 0));
  endtask

  // Random mix under the thread number last written.
  task automatic test_random(int count);
    repeat (count) send_instr(rand_instr());
  endtask

  // Hold the receiver off so the block fills and stalls its input.
  task automatic test_backpressure();
    hold_cycles = 60;
    repeat (20) send_instr(rand_instr());
    drain_results();
  endtask

  initial begin
    cfg_ch.valid = 1'b0; cfg_ch.data = '0;
    instr_ch.valid = 1'b0; instr_ch.payload = '0;
    foreach (gpr_q[i]) gpr_q[i] = '0;
    foreach (mem_q[i]) mem_q[i] = '0;
    {cr0_q, ctr_q, lr_q, msr_q, srr0_q, srr1_q, sprg0_q, sprg1_q} = '0;
    {lpcr_q, lpidr_q, hid6_q, resv_addr_q, resv_valid_q, thread_q} = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    drain_results();
    write_thread(6'd63);
    test_random(500);
    drain_results();
    write_thread(6'd0);
    idle_enable = 1'b0;
    test_random(300);
    idle_enable = 1'b1;
    drain_results();
    test_backpressure();
    write_thread(6'($urandom_range(63)));
    test_random(850);
    drain_results();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/ieu_pkg.sv
hw/rtl/ieu_instr_if.sv
hw/rtl/ieu_result_if.sv
hw/rtl/ieu_cfg_if.sv
hw/rtl/ieu_out_buf.sv
hw/rtl/ir_instruction_execute_unit.sv
hw/rtl/ieu_checker.sv
test/tb_ir_instruction_execute_unit_ifs.sv
test/tb_ir_instruction_execute_unit.sv
